// ----- src/positional_list_insert_delete_unit_defines.svh -----
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every edge out of reset
`define PLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list check failed");

// Next-cycle implication, checked on every edge out of reset
`define PLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list check failed");

`endif

// ----- src/plc_pkg.sv -----
package plc_pkg;

  // Field widths
  localparam int KIND_W  = 3;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // Default number of slots
  localparam int CAPACITY_DEF = 64;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // Broadcast control seen by every cell
  typedef struct packed {
    logic               ins;    // insert value at slot 'at'
    logic               del;    // remove slot 'at'
    logic               rd;     // drive slot 'at' onto the read taps
    logic [POS_W-1:0]   at;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- src/plc_req_if.sv -----
interface plc_req_if import plc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [KIND_W-1:0]  kind;
  logic signed [POS_W-1:0]   position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

// ----- src/plc_rsp_if.sv -----
interface plc_rsp_if import plc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic                      hit;
  logic        [STAT_W-1:0]  status;
  logic        [COUNT_W-1:0] count;

  modport source (output valid, read_value, hit, status, count, input ready);
  modport sink (input valid, read_value, hit, status, count, output ready);
endinterface

// ----- src/plc_cell.sv -----
module plc_cell import plc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [VALUE_W-1:0] left,   // value of slot IDX-1
  input  logic [VALUE_W-1:0] right,  // value of slot IDX+1
  output logic [VALUE_W-1:0] value,
  output logic [VALUE_W-1:0] tap
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  // Shift up on insert, shift down on delete, load at the insert slot
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX > ctrl.at) begin
        value <= left;
      end else if (MY_IDX == ctrl.at) begin
        value <= ctrl.value;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= ctrl.at) begin
        value <= right;
      end
    end
  end

  // Read tap: zero unless this slot is addressed
  assign tap = (ctrl.rd && (MY_IDX == ctrl.at)) ? value : '0;

endmodule

// ----- src/plc_gather.sv -----
module plc_gather import plc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic [VALUE_W-1:0] taps [CAPACITY],
  output logic [VALUE_W-1:0] result
);

  localparam int GRP   = 8;
  localparam int N_GRP = (CAPACITY + GRP - 1) / GRP;

  logic [VALUE_W-1:0] grp_or   [N_GRP];
  logic [VALUE_W-1:0] grp_next [N_GRP];

  // First level: OR taps in groups of eight
  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_next[g] = grp_next[g] | taps[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_or <= grp_next;
  end

  // Second level: OR of the registered groups
  always_comb begin
    result = '0;
    for (int g = 0; g < N_GRP; g++) begin
      result = result | grp_or[g];
    end
  end

endmodule

// ----- src/positional_list_insert_delete_unit.sv -----
// Channel | Dir | Beat contents
// --------+-----+--------------------------------------
// req     | in  | kind, position, value
// rsp     | out | read_value, hit, status, count
//
// A read, hit or miss, passes through S_EXEC and then S_FIN, the extra state for
// the registered OR tree over the cell taps; every other request ends in S_EXEC.
// One request is in flight at a time; req.ready rises when the unit is idle
// and the result register is empty or being emptied in that cycle.
// rsp holds its beat while rsp.ready is low. Synchronous reset clears the
// count and the handshake state; slot contents stay undefined until written.
module positional_list_insert_delete_unit import plc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  plc_req_if.sink   req,
  plc_rsp_if.source rsp
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_t;

  state_t               state;
  logic [KIND_W-1:0]    req_kind;
  logic [POS_W-1:0]     req_pos;
  logic [VALUE_W-1:0]   req_value;
  logic [COUNT_W-1:0]   count;
  logic                 out_valid;
  logic [VALUE_W-1:0]   out_value;
  logic                 out_hit;
  logic [STAT_W-1:0]    out_status;

  cell_ctrl_t           ctrl;
  logic                 hit_c;
  logic [STAT_W-1:0]    status_c;
  logic [COUNT_W-1:0]   count_next;
  logic                 want_ins;
  logic                 pos_neg;
  logic [POS_W-1:0]     pos_ext;
  logic [POS_W-1:0]     cnt_ext;
  logic                 in_range;
  logic                 is_full;

  logic [VALUE_W-1:0]   slot [CAPACITY];
  logic [VALUE_W-1:0]   taps [CAPACITY];
  logic [VALUE_W-1:0]   gathered;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.hit        = out_hit;
  assign rsp.status     = out_status;
  assign rsp.count      = count;

  // Request decode against the current count
  assign pos_neg  = req_pos[POS_W-1];
  assign pos_ext  = {1'b0, req_pos[POS_W-2:0]};
  assign cnt_ext  = {1'b0, count};
  assign in_range = !pos_neg && (pos_ext < cnt_ext);
  assign is_full  = (count == COUNT_W'(CAPACITY));

  always_comb begin
    ctrl       = '0;
    ctrl.value = req_value;
    hit_c      = 1'b0;
    status_c   = ST_DONE;
    count_next = count;
    want_ins   = 1'b0;
    case (req_kind)
      KIND_READ: begin
        ctrl.rd  = 1'b1;
        ctrl.at  = pos_ext;
        hit_c    = in_range;
        status_c = in_range ? ST_DONE : ST_IGNORED;
      end
      KIND_INS_FRONT: begin
        want_ins = 1'b1;
      end
      KIND_INS_BACK: begin
        want_ins = 1'b1;
        ctrl.at  = cnt_ext;
      end
      KIND_INS_POS: begin
        if (!pos_neg && (pos_ext > cnt_ext)) begin
          status_c = ST_IGNORED;
        end else begin
          want_ins = 1'b1;
          ctrl.at  = pos_neg ? '0 : pos_ext;
        end
      end
      KIND_DELETE: begin
        if (in_range) begin
          ctrl.del   = 1'b1;
          ctrl.at    = pos_ext;
          count_next = count - 1'b1;
        end else begin
          status_c = ST_IGNORED;
        end
      end
      default: begin
        status_c = ST_IGNORED;
      end
    endcase
    if (want_ins) begin
      if (is_full) begin
        status_c = ST_FULL;
      end else begin
        ctrl.ins   = 1'b1;
        count_next = count + 1'b1;
      end
    end
    // Cells act only in the execute cycle
    if (state != S_EXEC) begin
      ctrl.ins = 1'b0;
      ctrl.del = 1'b0;
      ctrl.rd  = 1'b0;
    end
  end

  // Chain of slot cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_in;
    logic [VALUE_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = slot[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = slot[i];
    end else begin : g_mid_r
      assign right_in = slot[i+1];
    end
    plc_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_in),
      .right (right_in),
      .value (slot[i]),
      .tap   (taps[i])
    );
  end

  plc_gather #(.CAPACITY(CAPACITY)) u_gather (
    .clk    (clk),
    .taps   (taps),
    .result (gathered)
  );

  // Sequencer, request latch and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_kind  <= req.kind;
            req_pos   <= req.position;
            req_value <= req.value;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          count      <= count_next;
          out_hit    <= hit_c;
          out_status <= status_c;
          out_value  <= '0;
          if (req_kind == KIND_READ) begin
            state <= S_FIN;
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FIN: begin
          out_value <= out_hit ? gathered : '0;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/plc_checker.sv -----
`include "positional_list_insert_delete_unit_defines.svh"

module plc_checker import plc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic [VALUE_W-1:0] read_value,
  input logic               hit,
  input logic [STAT_W-1:0]  status,
  input logic [COUNT_W-1:0] count
);

  // A hit is always a completed read
  `PLC_ASSERT_NOW(a_hit_done, rsp_valid && hit, status == ST_DONE)

  // Anything but a hit reports a zero value
  `PLC_ASSERT_NOW(a_miss_zero, rsp_valid && !hit, read_value == '0)

  // Full status only when the list is at capacity
  `PLC_ASSERT_NOW(a_full_count, rsp_valid && (status == ST_FULL),
                  count == COUNT_W'(CAPACITY))

  // Count never exceeds capacity
  `PLC_ASSERT_NOW(a_count_cap, 1'b1, count <= COUNT_W'(CAPACITY))

  // The result of an accepted beat is never shown in the next cycle
  `PLC_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready, !rsp_valid)

endmodule

bind positional_list_insert_delete_unit plc_checker #(.CAPACITY(CAPACITY)) u_plc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .read_value (rsp.read_value),
  .hit        (rsp.hit),
  .status     (rsp.status),
  .count      (rsp.count)
);
